[hw/rtl/qre_pkg.sv]
package qre_pkg;

  // Input word and sample format.
  localparam int SAMPLE_IN_W  = 16;
  localparam int SAMPLE_WIDTH = 16;

  // Moving-window length.
  localparam int WINDOW_LEN = 30;

  // Low-pass: y = 2*y1 - y2 + x - 2*x6 + x12.
  localparam int LP_W       = 22;
  localparam int LP_ACC_W   = 25;
  localparam int LP_DEPTH   = 12;
  localparam int LP_TAP_MID = 5;
  localparam int LP_TAP_END = 11;

  // High-pass held scaled by 32: H = H1 - x + 32*x16 - 32*x17 + x32.
  localparam int HP_DEPTH    = 32;
  localparam int HP_TAP_A    = 15;
  localparam int HP_TAP_B    = 16;
  localparam int HP_TAP_END  = 31;
  localparam int HP_SCALE_SH = 5;
  localparam int HP_SCALED_W = 28;
  localparam int HP_ACC_W    = 30;
  localparam int HP_SHIFT    = 5;
  localparam int HP_W        = HP_SCALED_W - HP_SHIFT;

  // Five-point derivative: 2*x + x1 - x3 - 2*x4, then floor shift.
  localparam int DER_DEPTH  = 4;
  localparam int DER_TAP_1  = 0;
  localparam int DER_TAP_3  = 2;
  localparam int DER_TAP_4  = 3;
  localparam int DER_ACC_W  = 26;
  localparam int DER_SHIFT  = 3;
  localparam int DER_W      = 22;

  // Squaring and window integration.
  localparam int PROD_W   = 2 * DER_W;
  localparam int SQ_W     = 42;
  localparam int SUM_W    = 47;
  localparam int ENERGY_W = 42;
  localparam int WPOS_W   = $clog2(WINDOW_LEN);
  localparam int FILL_W   = $clog2(WINDOW_LEN + 1);

  // Constant divider: long division one byte per stage, each byte
  // resolved by a reciprocal multiply on a narrow value.
  localparam int DIV_DIGIT_W     = 8;
  localparam int DIV_DIGITS      = (SUM_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
  localparam int DIV_W           = DIV_DIGITS * DIV_DIGIT_W;
  localparam int DIV_REM_W       = $clog2(WINDOW_LEN);
  localparam int DIV_STEP_W      = DIV_REM_W + DIV_DIGIT_W;
  localparam int DIV_RECIP_SHIFT = 20;
  localparam int DIV_RECIP       = ((2 ** DIV_RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int DIV_RECIP_W     = $clog2(DIV_RECIP + 1);
  localparam int DIV_PROD_W      = DIV_STEP_W + DIV_RECIP_W;

  typedef logic [SAMPLE_IN_W-1:0]         sample_in_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [LP_W-1:0]         lp_t;
  typedef logic signed [HP_SCALED_W-1:0]  hs_t;
  typedef logic signed [HP_W-1:0]         hp_t;
  typedef logic signed [DER_W-1:0]        der_t;
  typedef logic [SQ_W-1:0]                sq_t;
  typedef logic [SUM_W-1:0]               sum_t;
  typedef logic [ENERGY_W-1:0]            energy_t;

  typedef struct packed {
    sum_t sum;
    logic full;
  } win_word_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0]   rem;
    logic [DIV_DIGIT_W-1:0] quo;
  } div_step_t;

  // One long-division step: {rem_in, digit} / WINDOW_LEN, with rem_in below
  // WINDOW_LEN so the quotient fits in one digit.
  function automatic div_step_t div_step(logic [DIV_REM_W-1:0] rem_in,
                                         logic [DIV_DIGIT_W-1:0] digit);
    logic [DIV_STEP_W-1:0]  v;
    logic [DIV_PROD_W-1:0]  prod;
    logic [DIV_DIGIT_W-1:0] q;
    logic [DIV_STEP_W-1:0]  back;
    div_step_t              res;
    v        = {rem_in, digit};
    prod     = DIV_PROD_W'(v) * DIV_PROD_W'(DIV_RECIP);
    q        = prod[DIV_RECIP_SHIFT +: DIV_DIGIT_W];
    back     = DIV_STEP_W'(q) * DIV_STEP_W'(WINDOW_LEN);
    res.rem  = DIV_REM_W'(v - back);
    res.quo  = q;
    return res;
  endfunction

endpackage

[hw/rtl/qre_sample_if.sv]
interface qre_sample_if;
  import qre_pkg::*;

  logic       valid;
  logic       ready;
  sample_in_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

[hw/rtl/qre_energy_if.sv]
interface qre_energy_if;
  import qre_pkg::*;

  logic    valid;
  logic    ready;
  energy_t integrated_energy;
  logic    window_full;

  modport source (output valid, output integrated_energy, output window_full, input ready);
  modport sink (input valid, input integrated_energy, input window_full, output ready);
endinterface

[hw/rtl/qre_filter.sv]
module qre_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qre_pkg::SAMPLE_IN_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qre_pkg::sq_t                  square
);
  import qre_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] free;
  logic [NSTG-1:0] ld;

  sample_t x_q;
  lp_t     lp_q;
  hp_t     hp_q;
  der_t    der_q;
  sq_t     sq_q;

  sample_t lp_dly [LP_DEPTH];
  lp_t     lp_last;
  lp_t     lp_before;
  lp_t     hp_dly [HP_DEPTH];
  hs_t     hs_last;
  hp_t     der_dly [DER_DEPTH];

  logic signed [LP_ACC_W-1:0]  lp_acc;
  logic signed [HP_ACC_W-1:0]  hs_acc;
  logic signed [DER_ACC_W-1:0] der_acc;
  logic signed [PROD_W-1:0]    prod;
  lp_t  lp_next;
  hs_t  hs_next;
  hp_t  hp_next;
  der_t der_next;
  sq_t  sq_next;

  // A stage can take a word when it is empty or its word moves on.
  always_comb begin
    free[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
    ld[0] = in_valid && free[0];
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = vld[k-1] && free[k];
    end
  end

  assign in_ready  = free[0];
  assign out_valid = vld[NSTG-1];
  assign square    = sq_q;

  always_comb begin
    lp_acc = (LP_ACC_W'(lp_last) <<< 1) - LP_ACC_W'(lp_before) + LP_ACC_W'(x_q)
             - (LP_ACC_W'(lp_dly[LP_TAP_MID]) <<< 1) + LP_ACC_W'(lp_dly[LP_TAP_END]);
    lp_next = lp_acc[LP_W-1:0];

    hs_acc = HP_ACC_W'(hs_last) - HP_ACC_W'(lp_q)
             + (HP_ACC_W'(hp_dly[HP_TAP_A]) <<< HP_SCALE_SH)
             - (HP_ACC_W'(hp_dly[HP_TAP_B]) <<< HP_SCALE_SH)
             + HP_ACC_W'(hp_dly[HP_TAP_END]);
    hs_next = hs_acc[HP_SCALED_W-1:0];
    hp_next = hs_next[HP_SCALED_W-1:HP_SHIFT];

    der_acc = (DER_ACC_W'(hp_q) <<< 1) + DER_ACC_W'(der_dly[DER_TAP_1])
              - DER_ACC_W'(der_dly[DER_TAP_3]) - (DER_ACC_W'(der_dly[DER_TAP_4]) <<< 1);
    der_next = der_acc[DER_SHIFT +: DER_W];

    prod    = der_q * der_q;
    sq_next = prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= free[0] ? in_valid : vld[0];
      for (int k = 1; k < NSTG; k++) begin
        vld[k] <= free[k] ? vld[k-1] : vld[k];
      end
    end
  end

  // Recursion state moves only when a word enters the stage that owns it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LP_DEPTH; k++) begin
        lp_dly[k] <= '0;
      end
      for (int k = 0; k < HP_DEPTH; k++) begin
        hp_dly[k] <= '0;
      end
      for (int k = 0; k < DER_DEPTH; k++) begin
        der_dly[k] <= '0;
      end
      lp_last   <= '0;
      lp_before <= '0;
      hs_last   <= '0;
    end else begin
      if (ld[1]) begin
        lp_dly[0] <= x_q;
        for (int k = 1; k < LP_DEPTH; k++) begin
          lp_dly[k] <= lp_dly[k-1];
        end
        lp_before <= lp_last;
        lp_last   <= lp_next;
      end
      if (ld[2]) begin
        hp_dly[0] <= lp_q;
        for (int k = 1; k < HP_DEPTH; k++) begin
          hp_dly[k] <= hp_dly[k-1];
        end
        hs_last <= hs_next;
      end
      if (ld[3]) begin
        der_dly[0] <= hp_q;
        for (int k = 1; k < DER_DEPTH; k++) begin
          der_dly[k] <= der_dly[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x_q <= sample[SAMPLE_WIDTH-1:0];
    end
    if (ld[1]) begin
      lp_q <= lp_next;
    end
    if (ld[2]) begin
      hp_q <= hp_next;
    end
    if (ld[3]) begin
      der_q <= der_next;
    end
    if (ld[4]) begin
      sq_q <= sq_next;
    end
  end

endmodule

[hw/rtl/qre_window.sv]
module qre_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qre_pkg::sq_t       square,
  output logic               out_valid,
  input  logic               out_ready,
  output qre_pkg::win_word_t word
);
  import qre_pkg::*;

  sq_t               store [WINDOW_LEN];
  sum_t              sum;
  logic [FILL_W-1:0] fill;
  logic [WPOS_W-1:0] wpos;
  logic              vld;
  win_word_t         word_q;

  logic              free;
  logic              ld;
  logic              full_before;
  logic              full_next;
  sq_t               old;
  sum_t              sum_next;
  logic [FILL_W-1:0] fill_next;
  logic [WPOS_W-1:0] wpos_next;

  assign free      = !vld || out_ready;
  assign ld        = in_valid && free;
  assign in_ready  = free;
  assign out_valid = vld;
  assign word      = word_q;

  // The oldest square leaves the sum only once the window is full, so an
  // entry is never read before it has been written.
  always_comb begin
    full_before = (fill == FILL_W'(WINDOW_LEN));
    full_next   = full_before || (fill == FILL_W'(WINDOW_LEN - 1));
    old         = full_before ? store[wpos] : '0;
    sum_next    = sum - SUM_W'(old) + SUM_W'(square);
    fill_next   = full_before ? fill : fill + 1'b1;
    wpos_next   = (wpos == WPOS_W'(WINDOW_LEN - 1)) ? '0 : wpos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      sum  <= '0;
      fill <= '0;
      wpos <= '0;
    end else begin
      vld <= free ? in_valid : vld;
      if (ld) begin
        sum  <= sum_next;
        fill <= fill_next;
        wpos <= wpos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      store[wpos]  <= square;
      word_q.sum  <= full_next ? sum_next : '0;
      word_q.full <= full_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW_LEN))
    else $error("window fill count beyond window length");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    (fill == FILL_W'(WINDOW_LEN)) |=> (fill == FILL_W'(WINDOW_LEN)))
    else $error("window left the full state");

  a_pos_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != FILL_W'(WINDOW_LEN)) |-> (FILL_W'(wpos) == fill))
    else $error("write position out of step with fill count");

  a_zero_while_filling: assert property (@(posedge clk) disable iff (rst)
    (vld && !word_q.full) |-> (word_q.sum == '0))
    else $error("nonzero sum before the window is full");

endmodule

[hw/rtl/qre_div.sv]
module qre_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qre_pkg::win_word_t word,
  output logic               out_valid,
  input  logic               out_ready,
  output qre_pkg::energy_t   energy,
  output logic               full
);
  import qre_pkg::*;

  localparam int LAST = DIV_DIGITS - 1;

  logic [DIV_DIGITS-1:0] vld;
  logic [DIV_DIGITS-1:0] free;
  logic [DIV_DIGITS-1:0] ld;

  // Each stage holds the word shifted left by one digit per stage, with the
  // quotient digits filling in from the bottom.
  logic [DIV_W-1:0]     w_q    [DIV_DIGITS];
  logic [DIV_REM_W-1:0] rem_q  [DIV_DIGITS];
  logic                 full_q [DIV_DIGITS];

  logic [DIV_W-1:0]     src_w    [DIV_DIGITS];
  logic [DIV_REM_W-1:0] src_rem  [DIV_DIGITS];
  logic                 src_full [DIV_DIGITS];
  div_step_t            step     [DIV_DIGITS];

  always_comb begin
    free[LAST] = !vld[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
    ld[0] = in_valid && free[0];
    for (int k = 1; k < DIV_DIGITS; k++) begin
      ld[k] = vld[k-1] && free[k];
    end
  end

  always_comb begin
    src_w[0]    = DIV_W'(word.sum);
    src_rem[0]  = '0;
    src_full[0] = word.full;
    for (int k = 1; k < DIV_DIGITS; k++) begin
      src_w[k]    = w_q[k-1];
      src_rem[k]  = rem_q[k-1];
      src_full[k] = full_q[k-1];
    end
  end

  for (genvar j = 0; j < DIV_DIGITS; j++) begin : g_stage
    assign step[j] = div_step(src_rem[j], src_w[j][DIV_W-1 -: DIV_DIGIT_W]);

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        w_q[j]    <= {src_w[j][DIV_W-DIV_DIGIT_W-1:0], step[j].quo};
        rem_q[j]  <= step[j].rem;
        full_q[j] <= src_full[j];
      end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (rst)
      vld[j] |-> (rem_q[j] < DIV_REM_W'(WINDOW_LEN)))
      else $error("division remainder not below window length");
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= free[0] ? in_valid : vld[0];
      for (int k = 1; k < DIV_DIGITS; k++) begin
        vld[k] <= free[k] ? vld[k-1] : vld[k];
      end
    end
  end

  assign in_ready  = free[0];
  assign out_valid = vld[LAST];
  assign energy    = w_q[LAST][ENERGY_W-1:0];
  assign full      = full_q[LAST];

endmodule

[hw/rtl/qrs_energy_preprocessor.sv]
// Throughput: one word per cycle on both channels while energy.ready is held high.
// Reset (rst, synchronous, active high) empties the pipeline and clears all
// filter delay lines, the window sum and fill count; the window store needs
// no clearing, since an entry is only subtracted after it has been written.
module qrs_energy_preprocessor (
  input logic         clk,
  input logic         rst,
  qre_sample_if.sink  samples,
  qre_energy_if.source energy
);
  import qre_pkg::*;

  // The block is a twelve-register pipeline with a valid bit per stage:
  //   stage 0       input register (low SAMPLE_WIDTH bits, sign extended)
  //   stage 1       recursive low-pass, exact integer
  //   stage 2       high-pass kept scaled by 32, floor shift right by 5
  //   stage 3       five-point derivative, floor shift right by 3
  //   stage 4       squaring (one 22 by 22 multiplier)
  //   stage 5       moving-window running sum over the last WINDOW_LEN squares
  //   stages 6..11  division of the sum by WINDOW_LEN, one byte per stage
  // Each recursion is a single add with feedback inside its own stage, so
  // one sample per cycle is sustained while the output is ready. A stage takes
  // a new word whenever it is empty or its word moves on, so bubbles close up
  // and the input keeps flowing while a finished result waits at the output.

  logic      filt_valid;
  logic      filt_ready;
  sq_t       filt_square;
  logic      win_valid;
  logic      win_ready;
  win_word_t win_word;

  qre_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .sample    (samples.sample_in),
    .out_valid (filt_valid),
    .out_ready (filt_ready),
    .square    (filt_square)
  );

  // Until WINDOW_LEN squares have entered, the window stage passes a zero
  // sum with the full flag low, so the energy reads zero while filling.
  qre_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (filt_valid),
    .in_ready  (filt_ready),
    .square    (filt_square),
    .out_valid (win_valid),
    .out_ready (win_ready),
    .word      (win_word)
  );

  qre_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_ready  (win_ready),
    .word      (win_word),
    .out_valid (energy.valid),
    .out_ready (energy.ready),
    .energy    (energy.integrated_energy),
    .full      (energy.window_full)
  );

endmodule
